// ----- sv/ljpf_pkg.sv -----
package ljpf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int POS_W     = 24;
  localparam int LIMB      = 24;
  localparam int NL        = 15;
  localparam int W         = NL * LIMB;
  localparam int DW        = 2 * POS_W;
  localparam int D7_W      = 7 * DW;
  localparam int FORCE_W   = 48;
  localparam int QB        = FORCE_W - 1;
  localparam int SH        = QB - FRAC_BITS;
  localparam int IDX_W     = 3;

  localparam logic [POS_W-1:0] BOX_RST  = POS_W'(10 * (1 << FRAC_BITS));
  localparam logic [POS_W-1:0] ONE_RST  = POS_W'(1 << FRAC_BITS);
  localparam logic [POS_W-1:0] CUT_RST  = POS_W'(5 * (1 << (FRAC_BITS - 1)));

  typedef logic [W-1:0] wide_t;

  typedef enum logic [IDX_W-1:0] {
    REG_BOX_X   = 3'd0,
    REG_BOX_Y   = 3'd1,
    REG_BOX_Z   = 3'd2,
    REG_WELL    = 3'd3,
    REG_CONTACT = 3'd4,
    REG_CUTOFF  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [POS_W-1:0] first_x;
    logic [POS_W-1:0] first_y;
    logic [POS_W-1:0] first_z;
    logic [POS_W-1:0] second_x;
    logic [POS_W-1:0] second_y;
    logic [POS_W-1:0] second_z;
  } pair_t;

  typedef struct packed {
    logic signed [FORCE_W-1:0] force_x;
    logic signed [FORCE_W-1:0] force_y;
    logic signed [FORCE_W-1:0] force_z;
    logic                      in_range;
  } force_t;

endpackage

// ----- sv/ljpf_mac.sv -----
module ljpf_mac import ljpf_pkg::*; (
  input  wide_t           acc,
  input  wide_t           a,
  input  logic [LIMB-1:0] b,
  output wide_t           sum
);

  logic [W+LIMB-1:0] ev;
  logic [W+LIMB-1:0] od;
  logic [2*LIMB-1:0] p;

  // even and odd limb products do not overlap, so two vectors carry them all
  always_comb begin
    ev = '0;
    od = '0;
    p  = '0;
    for (int i = 0; i < NL; i++) begin
      p = (2*LIMB)'(a[i*LIMB +: LIMB]) * (2*LIMB)'(b);
      if ((i % 2) == 0) begin
        ev[i*LIMB +: 2*LIMB] = p;
      end else begin
        od[i*LIMB +: 2*LIMB] = p;
      end
    end
  end

  assign sum = W'(ev) + W'(od) + {acc[W-LIMB-1:0], {LIMB{1'b0}}};

endmodule

// ----- sv/ljpf_div_step.sv -----
module ljpf_div_step import ljpf_pkg::*; (
  input  logic [D7_W-1:0] rem,
  input  logic [D7_W-1:0] den,
  input  logic            din,
  output logic [D7_W-1:0] rem_next,
  output logic            qbit
);

  logic [D7_W:0]   t;
  logic [D7_W+1:0] diff;

  assign t        = {rem, din};
  assign diff     = {1'b0, t} - {2'b00, den};
  assign qbit     = ~diff[D7_W+1];
  assign rem_next = diff[D7_W+1] ? t[D7_W-1:0] : diff[D7_W-1:0];

endmodule

// ----- sv/lennard_jones_pair_force.sv -----
// Channel   Ports                          Handshake
// ------    -----------------------------  ------------------------------------
// input     pair                           taken at an edge with start & !busy
// result    result                         one cycle, marked by done
// config    wr_en, wr_index, wr_data       written at an edge with wr_en high
//
// One pair is taken every cycle; busy is high only during reset.
// Each taken pair passes an input register, four front stages (fold, squares,
// sum, range), twelve limb multiply stages, the axis product, the divider
// set-up, one restoring stage per quotient bit (47) and an output register.
// Reset clears the valid bits and loads the register defaults.
// The receiver cannot hold results off, so the pipeline never stalls.
module lennard_jones_pair_force import ljpf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  pair_t            pair,
  output logic             done,
  output force_t           result,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_index,
  input  logic [POS_W-1:0] wr_data
);

  localparam int NB   = 12;
  localparam int DS_W = DW + 2;
  localparam int HW   = DS_W + 7;
  localparam int CW   = D7_W + QB;
  localparam logic [HW-1:0] NEAR_LIM = HW'(1) << (2 * FRAC_BITS);

  typedef struct packed {
    logic                  valid;
    logic                  inr;
    logic [2:0][POS_W-1:0] mag;
    logic [2:0]            neg;
    logic [DW-1:0]         dd;
    wide_t                 pa;
    wide_t                 pacc;
    wide_t                 d3;
    logic                  bneg;
    wide_t                 br;
    wide_t                 cacc;
  } big_t;

  typedef struct packed {
    logic             valid;
    logic             inr;
    logic [2:0]       neg;
    logic [2:0][W-1:0] m;
    logic [D7_W-1:0]  d7;
  } ax_t;

  typedef struct packed {
    logic                 valid;
    logic                 inr;
    logic [2:0]           neg;
    logic [2:0]           sat;
    logic [2:0][D7_W-1:0] rem;
    logic [2:0][QB-1:0]   nl;
    logic [2:0][QB-1:0]   q;
    logic [D7_W-1:0]      den;
  } div_t;

  // configuration
  logic [POS_W-1:0] box_x, box_y, box_z, well, contact, cutoff;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_x   <= BOX_RST;
      box_y   <= BOX_RST;
      box_z   <= BOX_RST;
      well    <= ONE_RST;
      contact <= ONE_RST;
      cutoff  <= CUT_RST;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_BOX_X:   box_x   <= wr_data;
        REG_BOX_Y:   box_y   <= wr_data;
        REG_BOX_Z:   box_z   <= wr_data;
        REG_WELL:    well    <= wr_data;
        REG_CONTACT: contact <= wr_data;
        REG_CUTOFF:  cutoff  <= wr_data;
        default: ;
      endcase
    end
  end

  // derived constants: settle well before any item reaches them
  logic [DW-1:0] sig2, cut2;
  wide_t         sig4a, sig4, sig6a, sig6, cfa, cf;
  wide_t         sig4a_n, sig4_n, sig6a_n, sig6_n, cfa_n, cf_n;
  wide_t         two_sig6;
  logic [28:0]   e24;

  assign e24      = (29'(well) << 4) + (29'(well) << 3);
  assign two_sig6 = {sig6[W-2:0], 1'b0};

  ljpf_mac u_s4a (.acc('0), .a(W'(sig2)), .b(sig2[DW-1:LIMB]), .sum(sig4a_n));
  ljpf_mac u_s4  (.acc(sig4a), .a(W'(sig2)), .b(sig2[LIMB-1:0]), .sum(sig4_n));
  ljpf_mac u_s6a (.acc('0), .a(sig4), .b(sig2[DW-1:LIMB]), .sum(sig6a_n));
  ljpf_mac u_s6  (.acc(sig6a), .a(sig4), .b(sig2[LIMB-1:0]), .sum(sig6_n));
  ljpf_mac u_cfa (.acc('0), .a(sig6), .b(LIMB'(e24[28:LIMB])), .sum(cfa_n));
  ljpf_mac u_cf  (.acc(cfa), .a(sig6), .b(e24[LIMB-1:0]), .sum(cf_n));

  always_ff @(posedge clk) begin
    sig2  <= DW'(contact) * DW'(contact);
    cut2  <= DW'(cutoff) * DW'(cutoff);
    sig4a <= sig4a_n;
    sig4  <= sig4_n;
    sig6a <= sig6a_n;
    sig6  <= sig6_n;
    cfa   <= cfa_n;
    cf    <= cf_n;
  end

  // front end
  function automatic logic [POS_W:0] fold(input logic [POS_W-1:0] a,
                                          input logic [POS_W-1:0] b,
                                          input logic [POS_W-1:0] len);
    logic signed [POS_W+2:0] dd, ll, res;
    dd = $signed({3'b000, a}) - $signed({3'b000, b});
    ll = $signed({3'b000, len});
    priority if ((dd <<< 1) >= ll) begin
      res = dd - ll;
    end else if ((dd <<< 1) <= -ll) begin
      res = dd + ll;
    end else begin
      res = dd;
    end
    return res[POS_W:0];
  endfunction

  logic                  v1, v2, v3, v4;
  pair_t                 p1;
  logic [2:0][POS_W:0]   fd;
  logic [2:0][POS_W-1:0] mag2, mag3, mag4;
  logic [2:0]            neg2, neg3, neg4;
  logic [2:0][DW-1:0]    sq3;
  logic [DS_W-1:0]       dsum;
  logic [HW-1:0]         d100;
  big_t                  b0;
  big_t                  bg [NB+1];

  assign busy = rst;
  assign fd[0] = fold(p1.first_x, p1.second_x, box_x);
  assign fd[1] = fold(p1.first_y, p1.second_y, box_y);
  assign fd[2] = fold(p1.first_z, p1.second_z, box_z);

  always_ff @(posedge clk) begin
    p1 <= pair;
    for (int i = 0; i < 3; i++) begin
      neg2[i] <= fd[i][POS_W];
      mag2[i] <= fd[i][POS_W] ? POS_W'(-fd[i]) : fd[i][POS_W-1:0];
      sq3[i]  <= DW'(mag2[i]) * DW'(mag2[i]);
    end
    mag3 <= mag2;
    neg3 <= neg2;
    mag4 <= mag3;
    neg4 <= neg3;
    dsum <= DS_W'(sq3[0]) + DS_W'(sq3[1]) + DS_W'(sq3[2]);
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= start & ~busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  assign d100 = HW'(dsum) * HW'(100);

  always_comb begin
    b0       = '0;
    b0.valid = v4;
    b0.inr   = (d100 > NEAR_LIM) && (dsum < DS_W'(cut2));
    b0.mag   = mag4;
    b0.neg   = neg4;
    b0.dd    = dsum[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bg[0].valid <= 1'b0;
    end else begin
      bg[0] <= b0;
    end
  end

  // D^2, D^3, D^6, D^7 on one chain; C * |2S^3 - D^3| on the other
  for (genvar k = 0; k < NB; k++) begin : g_big
    wide_t           a_d, acc_d, sum_d, sum_c;
    logic [LIMB-1:0] b_d;
    big_t            nx;

    if (k >= 4 && k <= 9) begin : g_bd3
      if (k == 4) begin : g_first
        assign b_d = bg[k].pacc[(9-k)*LIMB +: LIMB];
      end else begin : g_rest
        assign b_d = bg[k].d3[(9-k)*LIMB +: LIMB];
      end
    end else if ((k % 2) == 0) begin : g_bhi
      assign b_d = bg[k].dd[DW-1:LIMB];
    end else begin : g_blo
      assign b_d = bg[k].dd[LIMB-1:0];
    end

    if (k >= 5) begin : g_cm
      ljpf_mac u_cm (
        .acc((k == 5) ? '0 : bg[k].cacc),
        .a  (cf),
        .b  (bg[k].br[(11-k)*LIMB +: LIMB]),
        .sum(sum_c)
      );
    end else begin : g_cz
      assign sum_c = bg[k].cacc;
    end

    always_comb begin
      if (k == 0) begin
        a_d   = W'(bg[k].dd);
        acc_d = '0;
      end else if (k == 2 || k == 4 || k == 10) begin
        a_d   = bg[k].pacc;
        acc_d = '0;
      end else begin
        a_d   = bg[k].pa;
        acc_d = bg[k].pacc;
      end
    end

    ljpf_mac u_dm (.acc(acc_d), .a(a_d), .b(b_d), .sum(sum_d));

    always_comb begin
      nx      = bg[k];
      nx.pa   = a_d;
      nx.pacc = sum_d;
      nx.cacc = sum_c;
      if (k == 4) begin
        nx.d3   = bg[k].pacc;
        nx.bneg = bg[k].pacc > two_sig6;
        nx.br   = (bg[k].pacc > two_sig6) ? bg[k].pacc - two_sig6
                                          : two_sig6 - bg[k].pacc;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        bg[k+1].valid <= 1'b0;
      end else begin
        bg[k+1] <= nx;
      end
    end
  end

  // per-axis numerator
  ax_t             ax, ax_n;
  logic [2:0][W-1:0] m_n;

  for (genvar i = 0; i < 3; i++) begin : g_ax
    ljpf_mac u_am (.acc('0), .a(bg[NB].cacc), .b(bg[NB].mag[i]), .sum(m_n[i]));
  end

  always_comb begin
    ax_n.valid = bg[NB].valid;
    ax_n.inr   = bg[NB].inr;
    ax_n.neg   = bg[NB].neg ^ {3{bg[NB].bneg}};
    ax_n.m     = m_n;
    ax_n.d7    = bg[NB].pacc[D7_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ax.valid <= 1'b0;
    end else begin
      ax <= ax_n;
    end
  end

  // divider set-up: saturate when the quotient reaches 2^47
  div_t dv [QB+1];
  div_t d0;

  always_comb begin
    d0       = '0;
    d0.valid = ax.valid;
    d0.inr   = ax.inr;
    d0.neg   = ax.neg;
    d0.den   = ax.d7;
    for (int i = 0; i < 3; i++) begin
      d0.sat[i] = CW'(ax.m[i]) >= (CW'(ax.d7) << SH);
      d0.rem[i] = D7_W'(ax.m[i] >> SH);
      d0.nl[i]  = {ax.m[i][SH-1:0], {FRAC_BITS{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].valid <= 1'b0;
    end else begin
      dv[0] <= d0;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [2:0][D7_W-1:0] rn;
    logic [2:0]           qb;
    div_t                 nx;

    for (genvar i = 0; i < 3; i++) begin : g_ax
      ljpf_div_step u_ds (
        .rem     (dv[j].rem[i]),
        .den     (dv[j].den),
        .din     (dv[j].nl[i][QB-1]),
        .rem_next(rn[i]),
        .qbit    (qb[i])
      );
    end

    always_comb begin
      nx     = dv[j];
      nx.rem = rn;
      for (int i = 0; i < 3; i++) begin
        nx.nl[i] = {dv[j].nl[i][QB-2:0], 1'b0};
        nx.q[i]  = {dv[j].q[i][QB-2:0], qb[i]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1].valid <= 1'b0;
      end else begin
        dv[j+1] <= nx;
      end
    end
  end

  // sign, saturate, zero the forces of out-of-range pairs
  localparam logic signed [FORCE_W-1:0] F_MAX = {1'b0, {QB{1'b1}}};
  localparam logic signed [FORCE_W-1:0] F_MIN = {1'b1, {QB{1'b0}}};

  logic signed [2:0][FORCE_W-1:0] fv;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!dv[QB].inr) begin
        fv[i] = '0;
      end else if (dv[QB].neg[i]) begin
        fv[i] = dv[QB].sat[i] ? F_MIN : -$signed({1'b0, dv[QB].q[i]});
      end else begin
        fv[i] = dv[QB].sat[i] ? F_MAX : $signed({1'b0, dv[QB].q[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    result.force_x  <= fv[0];
    result.force_y  <= fv[1];
    result.force_z  <= fv[2];
    result.in_range <= dv[QB].inr;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[QB].valid;
    end
  end

endmodule
